// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/rsam_pkg.sv -----
// ----------------------------------------------------------------------------
// rsam_pkg
// Field widths and fixed constants of the RAID5 stripe address mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsam_pkg;

    localparam int CFG_W    = 5;
    localparam int OFFSET_W = 48;
    localparam int DRIVE_W  = 4;
    localparam int STRIPE_W = 35;
    localparam int SLOT_W   = 4;
    localparam int DBO_W    = 47;

    // Drive count after reset and the smallest drive count that is honoured.
    localparam int DRIVES_RESET = 3;
    localparam int DRIVES_MIN   = 3;

    // Dividend bits resolved by each divider stage.
    localparam int DIV_STEPS = 8;

endpackage

// ----- rtl/rsam_req_if.sv -----
// ----------------------------------------------------------------------------
// rsam_req_if
// Request channel: one logical byte offset per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rsam_req_if;
    import rsam_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] byte_offset;

    modport source (output valid, output byte_offset, input ready);
    modport sink   (input valid, input byte_offset, output ready);

endinterface

// ----- rtl/rsam_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rsam_rsp_if
// Response channel: drive placement of one mapped offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rsam_rsp_if;
    import rsam_pkg::*;

    logic                valid;
    logic                ready;
    logic [DRIVE_W-1:0]  data_drive;
    logic [DRIVE_W-1:0]  parity_drive;
    logic [STRIPE_W-1:0] stripe_number;
    logic [SLOT_W-1:0]   chunk_slot;
    logic [DBO_W-1:0]    drive_byte_offset;

    modport source (
        output valid, output data_drive, output parity_drive, output stripe_number,
        output chunk_slot, output drive_byte_offset, input ready
    );
    modport sink (
        input valid, input data_drive, input parity_drive, input stripe_number,
        input chunk_slot, input drive_byte_offset, output ready
    );

endinterface

// ----- rtl/raid5_stripe_address_mapper.sv -----
// ----------------------------------------------------------------------------
// raid5_stripe_address_mapper
// Register stages: the divider stages, then the drive-map stage.
// Throughput: one request per cycle while responses are taken; the divider is pipelined at 8 bits a stage.
// Each stage stalls only when it is full and the next one cannot take its data.
// Reset clears all valid bits and sets the drive count to 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module raid5_stripe_address_mapper #(
    parameter int CHUNK_BYTES = 4096,
    parameter int MAX_DRIVES  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rsam_pkg::CFG_W-1:0] i_cfg_wdata,
    rsam_req_if.sink                   i_req,
    rsam_rsp_if.source                 o_rsp
);
    import rsam_pkg::*;

    localparam int LW   = $clog2(CHUNK_BYTES);
    localparam int CW   = OFFSET_W - LW;
    localparam int NSTG = (CW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int TW   = NSTG * DIV_STEPS;
    localparam int RDW  = $clog2(MAX_DRIVES);
    localparam int NW   = $clog2(MAX_DRIVES + 1);

    // Effective drive count; the clamp is applied when the register is written.
    logic [NW-1:0] r_drives;
    logic [NW-1:0] n_drives;

    always_comb begin
        if (int'(i_cfg_wdata) < DRIVES_MIN) begin
            n_drives = NW'(DRIVES_MIN);
        end else if (int'(i_cfg_wdata) > MAX_DRIVES) begin
            n_drives = NW'(MAX_DRIVES);
        end else begin
            n_drives = NW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drives <= NW'(DRIVES_RESET);
        end else if (i_cfg_we) begin
            r_drives <= n_drives;
        end
    end

    logic           s_valid [NSTG+1];
    logic           s_ready [NSTG+1];
    logic [TW-1:0]  s_x     [NSTG+1];
    logic [TW-1:0]  s_q     [NSTG+1];
    logic [RDW-1:0] s_r1    [NSTG+1];
    logic [RDW-1:0] s_r2    [NSTG+1];
    logic [LW-1:0]  s_low   [NSTG+1];
    logic [NW-1:0]  s_n     [NSTG+1];
    logic [NW-1:0]  w_map_n;

    // The chunk index is zero-padded at the top to a whole number of stages.
    assign s_valid[0] = i_req.valid;
    assign s_x[0]     = TW'(i_req.byte_offset[OFFSET_W-1:LW]);
    assign s_q[0]     = '0;
    assign s_r1[0]    = '0;
    assign s_r2[0]    = '0;
    assign s_low[0]   = i_req.byte_offset[LW-1:0];
    assign s_n[0]     = r_drives;
    assign i_req.ready = s_ready[0];

    for (genvar g = 0; g < NSTG; g++) begin : g_div
        rsam_div_stage #(
            .TW    (TW),
            .RDW   (RDW),
            .NW    (NW),
            .LW    (LW),
            .STEPS (DIV_STEPS)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (s_valid[g]),
            .o_ready_up (s_ready[g]),
            .i_x        (s_x[g]),
            .i_q        (s_q[g]),
            .i_r1       (s_r1[g]),
            .i_r2       (s_r2[g]),
            .i_low      (s_low[g]),
            .i_n        (s_n[g]),
            .o_valid    (s_valid[g+1]),
            .i_ready_dn (s_ready[g+1]),
            .o_x        (s_x[g+1]),
            .o_q        (s_q[g+1]),
            .o_r1       (s_r1[g+1]),
            .o_r2       (s_r2[g+1]),
            .o_low      (s_low[g+1]),
            .o_n        (s_n[g+1])
        );
    end

    rsam_drive_map #(
        .CW  (CW),
        .RDW (RDW),
        .NW  (NW),
        .LW  (LW)
    ) u_map (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (s_valid[NSTG]),
        .o_ready_up          (s_ready[NSTG]),
        .i_row               (s_q[NSTG][CW-1:0]),
        .i_slot              (s_r1[NSTG]),
        .i_cmod              (s_r2[NSTG]),
        .i_low               (s_low[NSTG]),
        .i_n                 (s_n[NSTG]),
        .o_valid             (o_rsp.valid),
        .i_ready_dn          (o_rsp.ready),
        .o_data_drive        (o_rsp.data_drive),
        .o_parity_drive      (o_rsp.parity_drive),
        .o_stripe_number     (o_rsp.stripe_number),
        .o_chunk_slot        (o_rsp.chunk_slot),
        .o_drive_byte_offset (o_rsp.drive_byte_offset),
        .o_n                 (w_map_n)
    );

    `ASSERT_NEXT(a_cfg_clamp, i_clk, i_rst_n, i_cfg_we, (r_drives >= NW'(DRIVES_MIN)) && (r_drives <= NW'(MAX_DRIVES)), "drive count outside its range")
    `ASSERT_IMPLIES(a_parity_range, i_clk, i_rst_n, o_rsp.valid, o_rsp.parity_drive < w_map_n, "parity drive beyond drive count")
    `ASSERT_IMPLIES(a_data_range, i_clk, i_rst_n, o_rsp.valid, o_rsp.data_drive < w_map_n, "data drive beyond drive count")
    `ASSERT_IMPLIES(a_slot_range, i_clk, i_rst_n, o_rsp.valid, o_rsp.chunk_slot < (w_map_n - NW'(1)), "chunk slot beyond data chunks")

endmodule

// ----- rtl/rsam_div_stage.sv -----
// ----------------------------------------------------------------------------
// rsam_div_stage
// One register stage of the pipelined chunk-index divider. It resolves STEPS
// dividend bits, dividing by the data chunks per stripe (drives minus one)
// with quotient, and by the drive count for the remainder alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsam_div_stage #(
    parameter int TW    = 40,
    parameter int RDW   = 4,
    parameter int NW    = 5,
    parameter int LW    = 12,
    parameter int STEPS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready_up,
    input  logic [TW-1:0]  i_x,
    input  logic [TW-1:0]  i_q,
    input  logic [RDW-1:0] i_r1,
    input  logic [RDW-1:0] i_r2,
    input  logic [LW-1:0]  i_low,
    input  logic [NW-1:0]  i_n,
    output logic           o_valid,
    input  logic           i_ready_dn,
    output logic [TW-1:0]  o_x,
    output logic [TW-1:0]  o_q,
    output logic [RDW-1:0] o_r1,
    output logic [RDW-1:0] o_r2,
    output logic [LW-1:0]  o_low,
    output logic [NW-1:0]  o_n
);

    localparam logic [RDW:0] ONE = (RDW+1)'(1);

    logic           r_valid;
    logic [TW-1:0]  r_x, n_x;
    logic [TW-1:0]  r_q, n_q;
    logic [RDW-1:0] r_r1, n_r1;
    logic [RDW-1:0] r_r2, n_r2;
    logic [LW-1:0]  r_low;
    logic [NW-1:0]  r_n;

    logic [RDW:0]   t_dm1;
    logic [RDW:0]   t_dn;
    logic [RDW:0]   t_a;
    logic [RDW:0]   t_b;
    logic           t_qb;

    assign t_dn  = (RDW+1)'(i_n);
    assign t_dm1 = t_dn - ONE;

    // Restoring division, most significant dividend bit first. The trial
    // value is below twice the divisor, so one subtraction settles each bit.
    always_comb begin
        n_x  = i_x;
        n_q  = i_q;
        n_r1 = i_r1;
        n_r2 = i_r2;
        t_a  = '0;
        t_b  = '0;
        t_qb = 1'b0;
        for (int k = 0; k < STEPS; k++) begin
            t_a  = {n_r1, n_x[TW-1]};
            t_b  = {n_r2, n_x[TW-1]};
            t_qb = (t_a >= t_dm1);
            if (t_qb) begin
                t_a = t_a - t_dm1;
            end
            if (t_b >= t_dn) begin
                t_b = t_b - t_dn;
            end
            n_r1 = t_a[RDW-1:0];
            n_r2 = t_b[RDW-1:0];
            n_q  = {n_q[TW-2:0], t_qb};
            n_x  = {n_x[TW-2:0], 1'b0};
        end
    end

    assign o_ready_up = !r_valid || i_ready_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready_up) begin
            r_x   <= n_x;
            r_q   <= n_q;
            r_r1  <= n_r1;
            r_r2  <= n_r2;
            r_low <= i_low;
            r_n   <= i_n;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_q     = r_q;
    assign o_r1    = r_r1;
    assign o_r2    = r_r2;
    assign o_low   = r_low;
    assign o_n     = r_n;

endmodule

// ----- rtl/rsam_drive_map.sv -----
// ----------------------------------------------------------------------------
// rsam_drive_map
// Final stage: rotates parity and data onto drives in the left-symmetric
// layout and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsam_drive_map #(
    parameter int CW  = 36,
    parameter int RDW = 4,
    parameter int NW  = 5,
    parameter int LW  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready_up,
    input  logic [CW-1:0]                 i_row,
    input  logic [RDW-1:0]                i_slot,
    input  logic [RDW-1:0]                i_cmod,
    input  logic [LW-1:0]                 i_low,
    input  logic [NW-1:0]                 i_n,
    output logic                          o_valid,
    input  logic                          i_ready_dn,
    output logic [rsam_pkg::DRIVE_W-1:0]  o_data_drive,
    output logic [rsam_pkg::DRIVE_W-1:0]  o_parity_drive,
    output logic [rsam_pkg::STRIPE_W-1:0] o_stripe_number,
    output logic [rsam_pkg::SLOT_W-1:0]   o_chunk_slot,
    output logic [rsam_pkg::DBO_W-1:0]    o_drive_byte_offset,
    output logic [NW-1:0]                 o_n
);
    import rsam_pkg::*;

    localparam logic [RDW:0] ONE = (RDW+1)'(1);

    logic                r_valid;
    logic [DRIVE_W-1:0]  r_data_drive, n_data_drive;
    logic [DRIVE_W-1:0]  r_parity_drive, n_parity_drive;
    logic [STRIPE_W-1:0] r_stripe_number, n_stripe_number;
    logic [SLOT_W-1:0]   r_chunk_slot, n_chunk_slot;
    logic [DBO_W-1:0]    r_drive_byte_offset, n_drive_byte_offset;
    logic [NW-1:0]       r_n;

    logic [RDW:0] t_n;
    logic [RDW:0] t_slot;
    logic [RDW:0] t_cmod;
    logic [RDW:0] t_rowmod;
    logic [RDW:0] t_par;
    logic [RDW:0] t_sum;
    logic [RDW:0] t_dat;

    assign t_n    = (RDW+1)'(i_n);
    assign t_slot = {1'b0, i_slot};
    assign t_cmod = {1'b0, i_cmod};

    // The chunk index is row * (n - 1) + slot, so row mod n equals
    // (slot - chunk index mod n) mod n.
    assign t_rowmod = (t_slot >= t_cmod) ? (t_slot - t_cmod) : (t_slot + t_n - t_cmod);
    assign t_par    = t_n - ONE - t_rowmod;
    assign t_sum    = t_par + ONE + t_slot;
    assign t_dat    = (t_sum >= t_n) ? (t_sum - t_n) : t_sum;

    assign n_data_drive        = DRIVE_W'(t_dat);
    assign n_parity_drive      = DRIVE_W'(t_par);
    assign n_stripe_number     = STRIPE_W'(i_row);
    assign n_chunk_slot        = SLOT_W'(i_slot);
    assign n_drive_byte_offset = DBO_W'({i_row, i_low});

    assign o_ready_up = !r_valid || i_ready_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready_up) begin
            r_data_drive        <= n_data_drive;
            r_parity_drive      <= n_parity_drive;
            r_stripe_number     <= n_stripe_number;
            r_chunk_slot        <= n_chunk_slot;
            r_drive_byte_offset <= n_drive_byte_offset;
            r_n                 <= i_n;
        end
    end

    assign o_valid             = r_valid;
    assign o_data_drive        = r_data_drive;
    assign o_parity_drive      = r_parity_drive;
    assign o_stripe_number     = r_stripe_number;
    assign o_chunk_slot        = r_chunk_slot;
    assign o_drive_byte_offset = r_drive_byte_offset;
    assign o_n                 = r_n;

endmodule

// ----- test/rsam_mapping_checker.sv -----
// ----------------------------------------------------------------------------
// rsam_mapping_checker
// Watches the request and response channels of the RAID5 stripe address
// mapper. It works out the left-symmetric placement of every accepted request
// and compares each response, field by field, with the oldest placement still
// outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsam_mapping_checker
    import rsam_pkg::*;
#(
    parameter int CHUNK_BYTES = 4096,
    parameter int MAX_DRIVES  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    rsam_req_if              i_req,
    rsam_rsp_if              i_rsp,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [DRIVE_W-1:0]  data_drive;
        logic [DRIVE_W-1:0]  parity_drive;
        logic [STRIPE_W-1:0] stripe_number;
        logic [SLOT_W-1:0]   chunk_slot;
        logic [DBO_W-1:0]    drive_byte_offset;
    } placement_t;

    placement_t       placements_q[$];
    logic [CFG_W-1:0] drive_count;

    function automatic placement_t place_offset(input logic [OFFSET_W-1:0] offset,
                                                input logic [CFG_W-1:0] count);
        longint unsigned drives;
        longint unsigned chunk;
        longint unsigned addr;
        longint unsigned row_bytes;
        longint unsigned stripe;
        longint unsigned slot;
        longint unsigned parity;
        placement_t      p;
        chunk  = CHUNK_BYTES;
        addr   = offset;
        drives = count;
        // Out-of-range drive counts are clamped when used, not when written.
        if (drives < DRIVES_MIN) drives = DRIVES_MIN;
        if (drives > MAX_DRIVES) drives = MAX_DRIVES;
        row_bytes = (drives - 1) * chunk;
        stripe    = addr / row_bytes;
        slot      = (addr % row_bytes) / chunk;
        parity    = (drives - 1) - (stripe % drives);
        p.data_drive        = DRIVE_W'((parity + 1 + slot) % drives);
        p.parity_drive      = DRIVE_W'(parity);
        p.stripe_number     = STRIPE_W'(stripe);
        p.chunk_slot        = SLOT_W'(slot);
        p.drive_byte_offset = DBO_W'(stripe * chunk + addr % chunk);
        return p;
    endfunction

    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        placement_t want;
        if (!i_rst_n) begin
            drive_count = CFG_W'(DRIVES_RESET);
            placements_q.delete();
        end else begin
            // Responses are taken first: none can belong to a request of this edge.
            if (i_rsp.valid && i_rsp.ready) begin
                if (placements_q.size() == 0) begin
                    $display("%0t: response with nothing outstanding, expected none, got %0d/%0d",
                             $time, i_rsp.stripe_number, i_rsp.drive_byte_offset);
                    o_fail_count++;
                end else begin
                    want = placements_q.pop_front();
                    report_field("data_drive", want.data_drive, i_rsp.data_drive);
                    report_field("parity_drive", want.parity_drive, i_rsp.parity_drive);
                    report_field("stripe_number", want.stripe_number, i_rsp.stripe_number);
                    report_field("chunk_slot", want.chunk_slot, i_rsp.chunk_slot);
                    report_field("drive_byte_offset", want.drive_byte_offset,
                                 i_rsp.drive_byte_offset);
                end
            end
            if (i_req.valid && i_req.ready)
                placements_q.push_back(place_offset(i_req.byte_offset, drive_count));
            if (i_cfg_we)
                drive_count = i_cfg_wdata;
        end
        o_pending = placements_q.size();
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the RAID5 stripe address mapper through a run of drive counts, in
// and out of the honoured range, with directed offsets first and random
// offsets after, under varying request gaps and response stalls. A separate
// checker predicts and compares; this module makes stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rsam_pkg::*;

    localparam int CHUNK_BYTES = 4096;
    localparam int MAX_DRIVES  = 16;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 12;
    localparam int NUM_PHASES  = 13;

    localparam logic [CFG_W-1:0] DRIVE_PLAN [NUM_PHASES] = '{
        5'd4, 5'd16, 5'd0, 5'd7, 5'd31, 5'd3, 5'd1, 5'd15, 5'd17, 5'd2, 5'd5, 5'd11, 5'd3
    };

    // Three drives give a stripe of 8192 data bytes; these straddle chunk and
    // stripe edges, the parity wrap and the ends of the offset field.
    localparam logic [OFFSET_W-1:0] DIRECTED_OFFSETS [15] = '{
        48'd0, 48'd1, 48'd4095, 48'd4096, 48'd8191, 48'd8192, 48'd8193, 48'd24575,
        48'd24576, 48'd28672, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_F000,
        48'h8000_0000_0000, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_requested;
    int               fail_count;
    int               pending;

    rsam_req_if req_if ();
    rsam_rsp_if rsp_if ();

    raid5_stripe_address_mapper #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .MAX_DRIVES (MAX_DRIVES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    rsam_mapping_checker #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .MAX_DRIVES (MAX_DRIVES)
    ) mapping_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("raid5_stripe_address_mapper verification failed");
        $finish;
    end

    // Response side: random stalls, or one long hold-off when asked for.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requested) begin
                hold_requested = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_offset(input logic [OFFSET_W-1:0] offset);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.byte_offset <= offset;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Stops offering requests and waits until every response has come back.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic write_drive_count(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [OFFSET_W-1:0] random_offset(input logic [CFG_W-1:0] count);
        longint unsigned drives;
        longint unsigned row_bytes;
        longint unsigned value;
        drives = count;
        if (drives < DRIVES_MIN) drives = DRIVES_MIN;
        if (drives > MAX_DRIVES) drives = MAX_DRIVES;
        row_bytes = (drives - 1) * CHUNK_BYTES;
        case ($urandom_range(3))
            0: value = {$urandom, $urandom};
            1: value = $urandom_range(0, 32'(40 * row_bytes));
            // Right on a stripe edge, or one byte either side of it.
            2: value = longint'($urandom) * row_bytes + $urandom_range(2) - 1;
            default: value = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 32'(3 * row_bytes));
        endcase
        return OFFSET_W'(value);
    endfunction

    initial begin
        req_if.valid       <= 1'b0;
        req_if.byte_offset <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requested = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_OFFSETS[i])
            send_offset(DIRECTED_OFFSETS[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_responses();
            write_drive_count(DRIVE_PLAN[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The pipeline fills and must stall its input during the hold-off.
                if (p == 0 && n == 10)
                    hold_requested = 1'b1;
                if (p == 4 && n == 20)
                    drain_responses();
                send_offset(random_offset(DRIVE_PLAN[p]));
            end
        end

        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("raid5_stripe_address_mapper verification clean");
        else
            $display("raid5_stripe_address_mapper verification failed");
        $finish;
    end

endmodule

// ----- raid5_stripe_address_mapper.f -----
+incdir+rtl
rtl/rsam_pkg.sv
rtl/rsam_req_if.sv
rtl/rsam_rsp_if.sv
rtl/rsam_div_stage.sv
rtl/rsam_drive_map.sv
rtl/raid5_stripe_address_mapper.sv
test/rsam_mapping_checker.sv
test/testbench.sv
